// File: hdl/qed_pkg.sv
// Types, codes and constants shared by the quadrature edge decoder.
package qed_pkg;

  localparam int unsigned POS_WIDTH = 32;
  localparam int unsigned OUT_POS_WIDTH = 32;

  typedef enum logic [1:0] {
    PIN_A  = 2'd0,
    PIN_B  = 2'd1,
    PIN_SW = 2'd2,
    PIN_NC = 2'd3
  } pin_e;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_CW   = 2'd1,
    STEP_CCW  = 2'd2,
    STEP_BAD  = 2'd3
  } step_e;

  typedef struct packed {
    logic [1:0] source_pin;
    logic       edge_rising;
    logic       level_a;
    logic       level_b;
  } qed_in_t;

  typedef struct packed {
    logic signed [OUT_POS_WIDTH-1:0] position;
    logic [1:0]                      step_taken;
  } qed_out_t;

endpackage

// File: hdl/quadrature_edge_decoder_unit.sv
// Top level of the quadrature edge decoder: input register, arm flags, position counter.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------
//   in      | sink      | in_valid_i / in_stall_o  | in_data_i  (qed_in_t)
//   out     | source    | out_valid_o / out_stall_i| out_data_o (qed_out_t)
//
// An edge event passes through the input register and then the result register;
// one event per cycle is sustained while out_stall_i stays low.
// The arm flags and the counter update as an event moves into the result register.
// Reset clears the flags, the counter and both valid bits.
// A stalled result holds; the input register then fills and in_stall_o rises.
module quadrature_edge_decoder_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  qed_pkg::qed_in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output qed_pkg::qed_out_t out_data_o
);
  import qed_pkg::*;

  logic                 in_valid_q;
  qed_in_t              in_q;
  logic                 out_valid_q;
  qed_out_t             out_q;
  logic                 cw_fall_q, ccw_fall_q, cw_rise_q, ccw_rise_q;
  logic                 cw_fall_d, ccw_fall_d, cw_rise_d, ccw_rise_d;
  logic [POS_WIDTH-1:0] pos_q, pos_d;
  step_e                step;
  logic                 advance;
  logic                 in_take;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    step       = STEP_NONE;
    cw_fall_d  = cw_fall_q;
    ccw_fall_d = ccw_fall_q;
    cw_rise_d  = cw_rise_q;
    ccw_rise_d = ccw_rise_q;
    unique case (pin_e'(in_q.source_pin))
      PIN_A: begin
        if (!in_q.edge_rising) begin
          if (in_q.level_b) cw_fall_d = 1'b1;
          if (ccw_fall_q && !in_q.level_b) step = STEP_CCW;
        end else begin
          if (!in_q.level_b) cw_rise_d = 1'b1;
          if (ccw_rise_q && in_q.level_b) step = STEP_CCW;
        end
      end
      PIN_B: begin
        if (!in_q.edge_rising) begin
          if (in_q.level_a) ccw_fall_d = 1'b1;
          if (cw_fall_q && !in_q.level_a) step = STEP_CW;
        end else begin
          if (!in_q.level_a) ccw_rise_d = 1'b1;
          if (cw_rise_q && in_q.level_a) step = STEP_CW;
        end
      end
      PIN_SW, PIN_NC: begin
        step = STEP_NONE;
      end
      default: begin
        step = STEP_NONE;
      end
    endcase
    pos_d = pos_q;
    if (step != STEP_NONE) begin
      cw_fall_d  = 1'b0;
      ccw_fall_d = 1'b0;
      cw_rise_d  = 1'b0;
      ccw_rise_d = 1'b0;
      if (step == STEP_CW) pos_d = pos_q + POS_WIDTH'(1);
      else                 pos_d = pos_q - POS_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cw_fall_q   <= 1'b0;
      ccw_fall_q  <= 1'b0;
      cw_rise_q   <= 1'b0;
      ccw_rise_q  <= 1'b0;
      pos_q       <= '0;
    end else begin
      if (in_take)                   in_valid_q <= 1'b1;
      else if (advance)              in_valid_q <= 1'b0;
      if (advance)                   out_valid_q <= 1'b1;
      else if (!out_stall_i)         out_valid_q <= 1'b0;
      if (advance) begin
        cw_fall_q  <= cw_fall_d;
        ccw_fall_q <= ccw_fall_d;
        cw_rise_q  <= cw_rise_d;
        ccw_rise_q <= ccw_rise_d;
        pos_q      <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_q <= in_data_i;
    if (advance) begin
      out_q.position   <= OUT_POS_WIDTH'(pos_d);
      out_q.step_taken <= step;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hdl/qed_checker.sv
// Port-level checks for the quadrature edge decoder and their bind.
module qed_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input qed_pkg::qed_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input qed_pkg::qed_out_t out_data_o
);
  import qed_pkg::*;

  logic out_xfer;

  assign out_xfer = out_valid_o && !out_stall_i;

  hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  step_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.step_taken != STEP_BAD)
    else $error("invalid step code");

  still_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer ##1 (out_xfer && out_data_o.step_taken == STEP_NONE)
    |-> out_data_o.position == $past(out_data_o.position))
    else $error("position moved without a step");

  cw_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer ##1 (out_xfer && out_data_o.step_taken == STEP_CW)
    |-> out_data_o.position == $past(out_data_o.position) + 32'sd1)
    else $error("clockwise step did not advance position");

  ccw_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer ##1 (out_xfer && out_data_o.step_taken == STEP_CCW)
    |-> out_data_o.position == $past(out_data_o.position) - 32'sd1)
    else $error("counter-clockwise step did not drop position");

endmodule

bind quadrature_edge_decoder_unit qed_checker u_qed_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// File: bench/quadrature_step_checker.sv
// Checker for the quadrature edge decoder: predicts each step and compares results.
module quadrature_step_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  qed_pkg::qed_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  qed_pkg::qed_out_t out_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);
  import qed_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  logic                 cw_fall_armed;
  logic                 ccw_fall_armed;
  logic                 cw_rise_armed;
  logic                 ccw_rise_armed;
  logic [POS_WIDTH-1:0] position_q;
  qed_out_t             step_results_q[$];
  int unsigned          mismatches;

  function automatic qed_out_t decode_edge(qed_in_t ev);
    step_e    step;
    qed_out_t res;
    step = STEP_NONE;
    case (ev.source_pin)
      PIN_A: begin
        if (ev.edge_rising) begin
          if (!ev.level_b) cw_rise_armed = 1'b1;
          if (ccw_rise_armed && ev.level_b) step = STEP_CCW;
        end else begin
          if (ev.level_b) cw_fall_armed = 1'b1;
          if (ccw_fall_armed && !ev.level_b) step = STEP_CCW;
        end
      end
      PIN_B: begin
        if (ev.edge_rising) begin
          if (!ev.level_a) ccw_rise_armed = 1'b1;
          if (cw_rise_armed && ev.level_a) step = STEP_CW;
        end else begin
          if (ev.level_a) ccw_fall_armed = 1'b1;
          if (cw_fall_armed && !ev.level_a) step = STEP_CW;
        end
      end
      default: ;
    endcase
    if (step != STEP_NONE) begin
      cw_fall_armed  = 1'b0;
      ccw_fall_armed = 1'b0;
      cw_rise_armed  = 1'b0;
      ccw_rise_armed = 1'b0;
      position_q = (step == STEP_CW) ? position_q + 1'b1 : position_q - 1'b1;
    end
    res.position   = position_q[OUT_POS_WIDTH-1:0];
    res.step_taken = step;
    return res;
  endfunction

  task automatic flag_mismatch(string field, longint expected, longint actual);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("mismatch in %s: expected %0d, got %0d", field, expected, actual);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    qed_out_t want;
    if (!rst_ni) begin
      cw_fall_armed  = 1'b0;
      ccw_fall_armed = 1'b0;
      cw_rise_armed  = 1'b0;
      ccw_rise_armed = 1'b0;
      position_q     = '0;
      step_results_q.delete();
      mismatches     = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (step_results_q.size() == 0) begin
          flag_mismatch("unexpected transfer", -1, longint'($signed(out_data_i.position)));
        end else begin
          want = step_results_q.pop_front();
          if (out_data_i.position !== want.position)
            flag_mismatch("position", longint'($signed(want.position)),
                          longint'($signed(out_data_i.position)));
          if (out_data_i.step_taken !== want.step_taken)
            flag_mismatch("step_taken", longint'(want.step_taken),
                          longint'(out_data_i.step_taken));
        end
      end
      if (in_valid_i && !in_stall_i) step_results_q.push_back(decode_edge(in_data_i));
    end
    fail_count_o <= mismatches;
    pending_o    <= 32'(step_results_q.size());
  end

endmodule

// File: bench/testbench.sv
// Top of the quadrature edge decoder bench: clock, reset, edge stimulus and verdict.
module testbench;
  import qed_pkg::*;

  localparam int unsigned EVENT_COUNT    = 1500;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned IDLE_PERCENT   = 14;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  qed_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  qed_out_t    out_data;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles = 0;
  logic        quiet = 1'b0;
  logic        enc_a;
  logic        enc_b;
  logic        turn_cw;
  int unsigned sent;

  always #4 clk = ~clk;

  quadrature_edge_decoder_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  quadrature_step_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(negedge clk) begin
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < IDLE_PERCENT);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("quadrature_edge_decoder_unit verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic qed_in_t edge_event(pin_e pin, logic rising, logic a, logic b);
    qed_in_t ev;
    ev.source_pin  = pin;
    ev.edge_rising = rising;
    ev.level_a     = a;
    ev.level_b     = b;
    return ev;
  endfunction

  task automatic send_event(qed_in_t ev);
    if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_data  <= ev;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic turn_encoder();
    logic move_a;
    move_a = ((enc_a == enc_b) == turn_cw);
    if (move_a) begin
      enc_a = ~enc_a;
      send_event(edge_event(PIN_A, enc_a, enc_a, enc_b));
    end else begin
      enc_b = ~enc_b;
      send_event(edge_event(PIN_B, enc_b, enc_a, enc_b));
    end
  endtask

  task automatic bounce_pin();
    pin_e pin;
    pin = $urandom_range(1) ? PIN_A : PIN_B;
    repeat (2) begin
      if (pin == PIN_A) enc_a = ~enc_a;
      else enc_b = ~enc_b;
      send_event(edge_event(pin, (pin == PIN_A) ? enc_a : enc_b, enc_a, enc_b));
    end
  endtask

  initial begin
    int unsigned pick;
    sent = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_event(edge_event(PIN_SW, 1'b0, 1'b1, 1'b1));
    send_event(edge_event(PIN_NC, 1'b1, 1'b0, 1'b0));
    send_event(edge_event(PIN_NC, 1'b1, 1'b1, 1'b1));
    send_event(edge_event(PIN_A, 1'b0, 1'b0, 1'b0));
    send_event(edge_event(PIN_B, 1'b1, 1'b1, 1'b1));
    send_event(edge_event(PIN_B, 1'b0, 1'b1, 1'b0));
    send_event(edge_event(PIN_A, 1'b0, 1'b0, 1'b0));
    send_event(edge_event(PIN_A, 1'b0, 1'b0, 1'b1));
    send_event(edge_event(PIN_A, 1'b0, 1'b0, 1'b1));
    send_event(edge_event(PIN_SW, 1'b1, 1'b0, 1'b1));
    send_event(edge_event(PIN_B, 1'b0, 1'b0, 1'b0));
    send_event(edge_event(PIN_A, 1'b1, 1'b1, 1'b0));
    send_event(edge_event(PIN_B, 1'b1, 1'b1, 1'b1));
    send_event(edge_event(PIN_B, 1'b1, 1'b0, 1'b1));
    send_event(edge_event(PIN_A, 1'b1, 1'b1, 1'b1));
    send_event(edge_event(PIN_A, 1'b0, 1'b0, 1'b1));
    send_event(edge_event(PIN_B, 1'b0, 1'b1, 1'b0));
    send_event(edge_event(PIN_A, 1'b0, 1'b0, 1'b0));
    send_event(edge_event(PIN_B, 1'b0, 1'b0, 1'b0));
    send_event(edge_event(PIN_B, 1'b1, 1'b0, 1'b1));
    send_event(edge_event(PIN_A, 1'b1, 1'b1, 1'b1));

    enc_a   = 1'b1;
    enc_b   = 1'b1;
    turn_cw = 1'b1;
    while (sent < EVENT_COUNT) begin
      quiet <= (sent >= 600 && sent < 900);
      pick = $urandom_range(99);
      if (pick < 70) begin
        if ($urandom_range(99) < 10) turn_cw = ~turn_cw;
        turn_encoder();
      end else if (pick < 78) begin
        bounce_pin();
      end else if (pick < 84) begin
        send_event(edge_event(PIN_SW, 1'($urandom_range(1)), enc_a, enc_b));
      end else begin
        send_event(qed_in_t'(5'($urandom_range(31))));
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("quadrature_edge_decoder_unit verification clean");
    end else begin
      $display("quadrature_edge_decoder_unit verification failed");
    end
    $finish;
  end

endmodule
